/* design/tsc_pkg.sv */
// Shared types and constants for the triggered scope capture block.
// No dependencies; used by the top level and by its checker.

package tsc_pkg;

   localparam int STORE_DEPTH_DEFAULT = 1024;
   localparam int SAMPLE_BITS_DEFAULT = 24;

   localparam int OP_BITS        = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   typedef enum logic [OP_BITS-1:0] {
      OP_CAPTURE = 2'd0,
      OP_READ    = 2'd1,
      OP_CLEAR   = 2'd2
   } op_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_TRIGGER_LEVEL  = 3'd0,
      REG_TRIGGER_ENABLE = 3'd1,
      REG_BYPASS         = 3'd2,
      REG_MONO_INPUT     = 3'd3,
      REG_CAPTURE_LENGTH = 3'd4
   } reg_index_type;

endpackage

/* design/triggered_scope_capture.sv */
// Two-channel scope capture with triggered single sweep and ring readout.
// Depends on tsc_pkg and tsc_ram.
//
// Request channel: a request is taken at a rising edge with start high and
// busy low. op selects capture (frame passes through and, unless bypassed
// or waiting for the trigger, is written to the left and right rings), read
// (one entry, oldest first) or clear. Every request gives one result, shown
// on the rsp_ ports for exactly one cycle with rsp_valid, in the cycle after
// the request is taken. A new request can be taken every cycle while busy is
// low; the ring RAMs are written and read in the accept cycle, and the RAM
// read is registered.
// A clear request zeroes all STORE_DEPTH entries of the rings in a sweep, one
// entry per cycle on the RAM write port; busy is high during the sweep.
// Writing capture_length zeroes the entries from the new length to the end,
// with busy high and csr_ready low.
// After reset the same sweep runs over all STORE_DEPTH entries before the
// first request is taken; configuration defaults apply at once.
// The receiver cannot stall: each result is consumed in its strobe cycle.

module triggered_scope_capture #(
   parameter int STORE_DEPTH = tsc_pkg::STORE_DEPTH_DEFAULT,
   parameter int SAMPLE_BITS = tsc_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  logic [tsc_pkg::OP_BITS-1:0]         req_op,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_left,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_right,
   input  logic                                req_read_channel,
   input  logic [$clog2(STORE_DEPTH)-1:0]      req_read_index,
   // result channel
   output logic                                rsp_valid,
   output logic signed [SAMPLE_BITS-1:0]       rsp_out_left,
   output logic signed [SAMPLE_BITS-1:0]       rsp_out_right,
   output logic signed [SAMPLE_BITS-1:0]       rsp_read_value,
   output logic                                rsp_read_valid,
   output logic                                rsp_armed_capturing,
   output logic [$clog2(STORE_DEPTH)-1:0]      rsp_write_position,
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tsc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [tsc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   import tsc_pkg::*;

   localparam int ADDR_BITS = $clog2(STORE_DEPTH);
   localparam int LEN_BITS  = $clog2(STORE_DEPTH + 1);
   localparam int SUM_BITS  = ADDR_BITS + 1;

   localparam logic [LEN_BITS-1:0]  LEN_MAX  = LEN_BITS'(STORE_DEPTH);
   localparam logic [ADDR_BITS-1:0] ADDR_END = ADDR_BITS'(STORE_DEPTH - 1);

   // configuration
   logic signed [SAMPLE_BITS-1:0] level_ff;
   logic                          trig_en_ff;
   logic                          bypass_ff;
   logic                          mono_ff;
   logic [LEN_BITS-1:0]           len_ff;

   // ring control
   logic [ADDR_BITS-1:0]          wp_ff;
   logic                          active_ff;
   logic                          clearing_ff;
   logic [ADDR_BITS-1:0]          clr_addr_ff;

   // result registers
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] out_left_ff;
   logic signed [SAMPLE_BITS-1:0] out_right_ff;
   logic                          rd_valid_ff;
   logic                          rd_chan_ff;
   logic                          armed_ff;
   logic [ADDR_BITS-1:0]          wpos_ff;

   logic                          accept;
   logic                          csr_write;

   // capture path
   logic                          trig_hit;
   logic                          act_set;
   logic [ADDR_BITS-1:0]          wp_base;
   logic                          cap_write;
   logic [LEN_BITS-1:0]           wp_inc;
   logic [ADDR_BITS-1:0]          wp_after;
   logic                          cap_en;

   // read path
   logic [SUM_BITS-1:0]           rd_sum;
   logic [SUM_BITS-1:0]           len_ext;
   logic [SUM_BITS-1:0]           rd_pos;
   logic                          idx_ok;

   // next-state values
   logic [ADDR_BITS-1:0]          wp_in;
   logic                          active_in;

   // RAM ports
   logic                          ram_we;
   logic [ADDR_BITS-1:0]          ram_waddr;
   logic [SAMPLE_BITS-1:0]        ram_wdata_l;
   logic [SAMPLE_BITS-1:0]        ram_wdata_r;
   logic [SAMPLE_BITS-1:0]        ram_rdata_l;
   logic [SAMPLE_BITS-1:0]        ram_rdata_r;

   // length write decode
   logic [LEN_BITS-1:0]           len_raw;
   logic [LEN_BITS-1:0]           len_new;

   assign accept    = start && !clearing_ff;
   assign csr_write = csr_valid && !clearing_ff;

   // wp_ff always stays below len_ff, so no modulo is needed on it
   assign trig_hit  = trig_en_ff && !active_ff && (req_sample_left >= level_ff);
   assign act_set   = active_ff || trig_hit;
   assign wp_base   = trig_hit ? '0 : wp_ff;
   assign cap_write = !trig_en_ff || act_set;
   assign wp_inc    = LEN_BITS'(wp_base) + LEN_BITS'(1);
   assign wp_after  = (wp_inc == len_ff) ? '0 : ADDR_BITS'(wp_inc);
   assign cap_en    = accept && (req_op == OP_CAPTURE) && !bypass_ff;

   // for idx below the length, wp + idx stays below twice it: one conditional subtract
   assign len_ext = SUM_BITS'(len_ff);
   assign rd_sum  = SUM_BITS'(wp_ff) + SUM_BITS'(req_read_index);
   assign rd_pos  = (rd_sum >= len_ext) ? (rd_sum - len_ext) : rd_sum;
   assign idx_ok  = SUM_BITS'(req_read_index) < len_ext;

   always_comb begin
      wp_in     = wp_ff;
      active_in = active_ff;
      if (cap_en) begin
         active_in = act_set;
         wp_in     = wp_base;
         if (cap_write) begin
            wp_in = wp_after;
            if (trig_en_ff && (wp_after == '0)) begin
               active_in = 1'b0;
            end
         end
      end
   end

   always_comb begin
      if (clearing_ff) begin
         ram_we      = 1'b1;
         ram_waddr   = clr_addr_ff;
         ram_wdata_l = '0;
         ram_wdata_r = '0;
      end else begin
         ram_we      = cap_en && cap_write;
         ram_waddr   = wp_base;
         ram_wdata_l = req_sample_left;
         ram_wdata_r = mono_ff ? req_sample_left : req_sample_right;
      end
   end

   always_comb begin
      len_raw = csr_wdata[LEN_BITS-1:0];
      priority if (len_raw == '0) begin
         len_new = LEN_BITS'(1);
      end else if (len_raw > LEN_MAX) begin
         len_new = LEN_MAX;
      end else begin
         len_new = len_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= '0;
         trig_en_ff   <= 1'b0;
         bypass_ff    <= 1'b0;
         mono_ff      <= 1'b0;
         len_ff       <= LEN_MAX;
         wp_ff        <= '0;
         active_ff    <= 1'b0;
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;

         if (clearing_ff) begin
            if (clr_addr_ff == ADDR_END) begin
               clearing_ff <= 1'b0;
            end
            clr_addr_ff <= clr_addr_ff + ADDR_BITS'(1);
         end

         if (accept) begin
            out_left_ff  <= '0;
            out_right_ff <= '0;
            rd_valid_ff  <= 1'b0;
            rd_chan_ff   <= req_read_channel;
            unique case (req_op)
               OP_CAPTURE: begin
                  out_left_ff  <= req_sample_left;
                  out_right_ff <= req_sample_right;
                  wp_ff        <= wp_in;
                  active_ff    <= active_in;
                  armed_ff     <= active_in;
                  wpos_ff      <= wp_in;
               end
               OP_READ: begin
                  rd_valid_ff <= idx_ok;
                  armed_ff    <= active_ff;
                  wpos_ff     <= wp_ff;
               end
               OP_CLEAR: begin
                  wp_ff       <= '0;
                  active_ff   <= 1'b0;
                  armed_ff    <= 1'b0;
                  wpos_ff     <= '0;
                  clearing_ff <= 1'b1;
                  clr_addr_ff <= '0;
               end
               default: begin
                  armed_ff <= active_ff;
                  wpos_ff  <= wp_ff;
               end
            endcase
         end

         if (csr_write) begin
            unique case (csr_index)
               REG_TRIGGER_LEVEL:  level_ff   <= csr_wdata[SAMPLE_BITS-1:0];
               REG_TRIGGER_ENABLE: trig_en_ff <= csr_wdata[0];
               REG_BYPASS:         bypass_ff  <= csr_wdata[0];
               REG_MONO_INPUT:     mono_ff    <= csr_wdata[0];
               REG_CAPTURE_LENGTH: begin
                  len_ff <= len_new;
                  wp_ff  <= '0;
                  // entries past the new length read back as zero later
                  if (len_new != LEN_MAX) begin
                     clearing_ff <= 1'b1;
                     clr_addr_ff <= ADDR_BITS'(len_new);
                  end
               end
               default: ;
            endcase
         end
      end
   end

   tsc_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_left_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata_l),
      .rd_addr (rd_pos[ADDR_BITS-1:0]),
      .rd_data (ram_rdata_l)
   );

   tsc_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_right_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata_r),
      .rd_addr (rd_pos[ADDR_BITS-1:0]),
      .rd_data (ram_rdata_r)
   );

   assign busy                = clearing_ff;
   assign csr_ready           = !clearing_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_left        = out_left_ff;
   assign rsp_out_right       = out_right_ff;
   assign rsp_read_valid      = rd_valid_ff;
   assign rsp_read_value      = !rd_valid_ff ? '0 :
                                (rd_chan_ff ? ram_rdata_r : ram_rdata_l);
   assign rsp_armed_capturing = armed_ff;
   assign rsp_write_position  = wpos_ff;

endmodule

/* design/tsc_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module tsc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/tsc_checker.sv */
// Port-level checks for triggered_scope_capture, bound to the top level.
// Depends on tsc_pkg.

module tsc_checker #(
   parameter int STORE_DEPTH = tsc_pkg::STORE_DEPTH_DEFAULT,
   parameter int SAMPLE_BITS = tsc_pkg::SAMPLE_BITS_DEFAULT
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic [tsc_pkg::OP_BITS-1:0]        req_op,
   input logic                               rsp_valid,
   input logic [SAMPLE_BITS-1:0]             rsp_read_value,
   input logic                               rsp_read_valid,
   input logic                               rsp_armed_capturing,
   input logic [$clog2(STORE_DEPTH)-1:0]     rsp_write_position
);

   import tsc_pkg::*;

   // each request gives its result in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid)
      else $error("no result after accepted request");

   a_invalid_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_read_valid |-> rsp_read_value == '0)
      else $error("read value nonzero without read_valid");

   a_clear_status: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_op == OP_CLEAR |=>
         !rsp_armed_capturing && rsp_write_position == '0 && busy)
      else $error("clear request left state or did not sweep");

   a_valid_only_read: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_op != OP_READ |=> !rsp_read_valid)
      else $error("read_valid on a non-read request");

endmodule

bind triggered_scope_capture tsc_checker #(
   .STORE_DEPTH (STORE_DEPTH),
   .SAMPLE_BITS (SAMPLE_BITS)
) u_tsc_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .req_op              (req_op),
   .rsp_valid           (rsp_valid),
   .rsp_read_value      (rsp_read_value),
   .rsp_read_valid      (rsp_read_valid),
   .rsp_armed_capturing (rsp_armed_capturing),
   .rsp_write_position  (rsp_write_position)
);

/* verif/testbench.sv */
// Self-checking testbench for triggered_scope_capture.
// Depends on tsc_pkg and the block's RTL; predicts every result in-line and
// compares it against the rsp_ ports while driving requests and register writes.

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tsc_pkg::*;

   localparam int DEPTH         = STORE_DEPTH_DEFAULT;
   localparam int SBITS         = SAMPLE_BITS_DEFAULT;
   localparam int IBITS         = $clog2(DEPTH);
   localparam int LIMIT_CYCLES  = 800000;
   localparam int RANDOM_TARGET = 925;
   localparam int MAX_REPORTS   = 50;

   // op code with no defined operation, and a register index with no register
   localparam logic [OP_BITS-1:0]        OP_UNDEFINED = 2'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNMAPPED = 3'd5;

   typedef logic signed [SBITS-1:0] sample_type;

   typedef struct packed {
      sample_type       out_left;
      sample_type       out_right;
      sample_type       read_value;
      logic             read_valid;
      logic             armed;
      logic [IBITS-1:0] wpos;
   } frame_result_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [OP_BITS-1:0]        req_op;
   sample_type                req_sample_left;
   sample_type                req_sample_right;
   logic                      req_read_channel;
   logic [IBITS-1:0]          req_read_index;
   logic                      rsp_valid;
   sample_type                rsp_out_left;
   sample_type                rsp_out_right;
   sample_type                rsp_read_value;
   logic                      rsp_read_valid;
   logic                      rsp_armed_capturing;
   logic [IBITS-1:0]          rsp_write_position;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   // predicted state of the block
   sample_type  ring_left [DEPTH];
   sample_type  ring_right [DEPTH];
   int unsigned ring_wptr;
   int unsigned ring_len;
   bit          sweep_on;
   sample_type  trig_level;
   bit          trig_en;
   bit          bypass_on;
   bit          mono_on;

   frame_result_type expected_results[$];

   int err_count   = 0;
   int cycle_count = 0;
   int n_capture   = 0;
   int n_read      = 0;
   int n_clear     = 0;
   int n_other     = 0;
   int n_csr       = 0;
   int burst_left  = 0;
   bit start_on    = 1'b0;

   triggered_scope_capture #(
      .STORE_DEPTH(DEPTH),
      .SAMPLE_BITS(SBITS)
   ) u_top (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("FAIL");
         $finish;
      end
   end

   task automatic zero_rings(input int unsigned first);
      for (int unsigned i = first; i < DEPTH; i++) begin
         ring_left[i]  = '0;
         ring_right[i] = '0;
      end
   endtask

   task automatic reset_predictor();
      zero_rings(0);
      ring_wptr  = 0;
      ring_len   = DEPTH;
      sweep_on   = 1'b0;
      trig_level = '0;
      trig_en    = 1'b0;
      bypass_on  = 1'b0;
      mono_on    = 1'b0;
   endtask

   task automatic predict_frame(input logic [OP_BITS-1:0] op, input sample_type left,
                                input sample_type right, input logic chan,
                                input logic [IBITS-1:0] idx);
      frame_result_type res;
      int unsigned      wp;
      int unsigned      pos;
      res = '0;
      case (op)
         OP_CAPTURE: begin
            n_capture++;
            res.out_left  = left;
            res.out_right = right;
            if (!bypass_on) begin
               if (trig_en && !sweep_on && left >= trig_level) begin
                  sweep_on  = 1'b1;
                  ring_wptr = 0;
               end
               if (!trig_en || sweep_on) begin
                  wp             = ring_wptr % ring_len;
                  ring_left[wp]  = left;
                  ring_right[wp] = mono_on ? left : right;
                  ring_wptr      = (wp + 1) % ring_len;
                  // one full wrap ends a triggered sweep
                  if (trig_en && ring_wptr == 0)
                     sweep_on = 1'b0;
               end
            end
         end
         OP_READ: begin
            n_read++;
            if (idx < ring_len) begin
               pos            = (ring_wptr + idx) % ring_len;
               res.read_value = chan ? ring_right[pos] : ring_left[pos];
               res.read_valid = 1'b1;
            end
         end
         OP_CLEAR: begin
            n_clear++;
            zero_rings(0);
            ring_wptr = 0;
            sweep_on  = 1'b0;
         end
         default: begin
            n_other++;
         end
      endcase
      res.armed = sweep_on;
      res.wpos  = ring_wptr[IBITS-1:0];
      expected_results.push_back(res);
   endtask

   task automatic predict_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                              input logic [CSR_DATA_BITS-1:0] data);
      int unsigned len;
      case (idx)
         REG_TRIGGER_LEVEL:  trig_level = data[SBITS-1:0];
         REG_TRIGGER_ENABLE: trig_en    = data[0];
         REG_BYPASS:         bypass_on  = data[0];
         REG_MONO_INPUT:     mono_on    = data[0];
         REG_CAPTURE_LENGTH: begin
            len = 32'(data[IBITS:0]);
            if (len == 0)
               len = 1;
            if (len > DEPTH)
               len = DEPTH;
            ring_len = len;
            zero_rings(len);
            ring_wptr = 0;
         end
         default: ;
      endcase
   endtask

   task automatic drive_idle();
      if (start_on) begin
         start    <= 1'b0;
         start_on  = 1'b0;
      end
   endtask

   // busy is sampled at the falling edge, the queue at the rising edge
   task automatic wait_drained();
      bit idle_seen;
      do begin
         @(negedge clock);
         idle_seen = !busy;
         @(posedge clock);
      end while (!idle_seen || expected_results.size() != 0);
   endtask

   task automatic send_request(input logic [OP_BITS-1:0] op, input sample_type left,
                               input sample_type right, input logic chan,
                               input logic [IBITS-1:0] idx);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            drive_idle();
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_op           <= op;
      req_sample_left  <= left;
      req_sample_right <= right;
      req_read_channel <= chan;
      req_read_index   <= idx;
      start            <= 1'b1;
      start_on          = 1'b1;
      do @(negedge clock); while (busy);
      @(posedge clock);
      predict_frame(op, left, right, chan, idx);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      drive_idle();
      wait_drained();
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
      predict_csr(idx, data);
      n_csr++;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         err_count++;
         if (err_count <= MAX_REPORTS)
            $display("%0t: %s expected %h got %h", $time, name, want, got);
      end
   endtask

   always @(negedge clock) begin : check_results
      frame_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
               $display("%0t: unexpected result, expected none got read_value %h",
                        $time, rsp_read_value);
         end else begin
            want = expected_results.pop_front();
            check_field("out_left", 32'(want.out_left), 32'(rsp_out_left));
            check_field("out_right", 32'(want.out_right), 32'(rsp_out_right));
            check_field("read_value", 32'(want.read_value), 32'(rsp_read_value));
            check_field("read_valid", 32'(want.read_valid), 32'(rsp_read_valid));
            check_field("armed_capturing", 32'(want.armed), 32'(rsp_armed_capturing));
            check_field("write_position", 32'(want.wpos), 32'(rsp_write_position));
         end
      end
   end

   task automatic test_sample_extremes();
      send_request(OP_CAPTURE, 24'h7FFFFF, 24'h800000, 1'b0, '0);
      send_request(OP_CAPTURE, 24'h800000, 24'h7FFFFF, 1'b1, '1);
      send_request(OP_CAPTURE, 24'hAAAAAA, 24'h555555, 1'b0, '0);
      send_request(OP_READ, '0, '0, 1'b0, 10'd1021);
      send_request(OP_READ, '0, '0, 1'b1, '1);
      send_request(OP_READ, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 10'd1022);
   endtask

   task automatic test_unknown_op();
      send_request(OP_UNDEFINED, 24'h123456, 24'hFEDCBA, 1'b1, 10'd5);
   endtask

   task automatic test_length_limits();
      csr_write(REG_CAPTURE_LENGTH, 32'd0);      // taken as one entry
      send_request(OP_CAPTURE, 24'h000001, 24'hFFFFFF, 1'b0, '0);
      send_request(OP_READ, '0, '0, 1'b1, 10'd0);
      send_request(OP_READ, '0, '0, 1'b0, 10'd1);
      csr_write(REG_CAPTURE_LENGTH, 32'hFFFF_F7FF); // saturates at full depth
      csr_write(REG_CAPTURE_LENGTH, 32'd3);
      csr_write(REG_UNMAPPED, 32'hFFFF_FFFF);
   endtask

   task automatic test_mono_and_bypass();
      csr_write(REG_MONO_INPUT, 32'd1);
      send_request(OP_CAPTURE, 24'h111111, 24'h222222, 1'b0, '0);
      send_request(OP_CAPTURE, 24'h333333, 24'h444444, 1'b0, '0);
      send_request(OP_CAPTURE, 24'h555555, 24'h666666, 1'b0, '0);
      send_request(OP_CAPTURE, 24'h777777, 24'h888888, 1'b0, '0);
      send_request(OP_READ, '0, '0, 1'b1, 10'd0);
      send_request(OP_READ, '0, '0, 1'b0, 10'd3);
      csr_write(REG_MONO_INPUT, 32'd0);
      csr_write(REG_BYPASS, 32'd1);
      send_request(OP_CAPTURE, 24'h0F0F0F, 24'hF0F0F0, 1'b0, '0);
      send_request(OP_READ, '0, '0, 1'b0, 10'd2);
      csr_write(REG_BYPASS, 32'd0);
   endtask

   task automatic test_trigger_sweep();
      csr_write(REG_TRIGGER_LEVEL, 32'hFF20_0000);  // upper bits are don't-care
      csr_write(REG_TRIGGER_ENABLE, 32'd1);
      csr_write(REG_CAPTURE_LENGTH, 32'd3);
      send_request(OP_CAPTURE, 24'h1FFFFF, 24'h000010, 1'b0, '0);  // just below
      send_request(OP_CAPTURE, 24'h200000, 24'h000020, 1'b0, '0);  // exactly at
      send_request(OP_CAPTURE, 24'h7FFFFF, 24'h000030, 1'b0, '0);
      send_request(OP_CAPTURE, 24'h800000, 24'h000040, 1'b0, '0);  // wrap disarms
      send_request(OP_CAPTURE, 24'h300000, 24'h000050, 1'b0, '0);  // rearm
      csr_write(REG_TRIGGER_ENABLE, 32'd0);  // disabled mid-sweep
      send_request(OP_CAPTURE, 24'h000000, 24'h000060, 1'b0, '0);
      send_request(OP_CLEAR, 24'hFFFFFF, 24'hFFFFFF, 1'b1, '1);
      csr_write(REG_TRIGGER_LEVEL, 32'h0080_0000);  // most negative level
   endtask

   task automatic test_random_traffic();
      int unsigned        sent;
      int unsigned        n;
      int unsigned        sel;
      int unsigned        len;
      logic [OP_BITS-1:0] op;
      sample_type         left;
      sample_type         right;
      logic               chan;
      logic [IBITS-1:0]   idx;
      sent = 0;
      while (sent < RANDOM_TARGET) begin
         if ($urandom_range(0, 2) != 0)
            csr_write(REG_TRIGGER_LEVEL, $urandom());
         if ($urandom_range(0, 2) != 0)
            csr_write(REG_TRIGGER_ENABLE, $urandom());
         if ($urandom_range(0, 2) == 0)
            csr_write(REG_BYPASS, ($urandom() & 32'hFFFF_FFFE) |
                                  32'($urandom_range(0, 6) == 0));
         if ($urandom_range(0, 2) == 0)
            csr_write(REG_MONO_INPUT, $urandom());
         if ($urandom_range(0, 19) == 0)
            csr_write(REG_UNMAPPED, $urandom());
         sel = $urandom_range(0, 9);
         if (sel < 7)
            len = $urandom_range(1, 16);
         else if (sel < 9)
            len = $urandom_range(17, 128);
         else
            len = $urandom_range(0, 2047);
         csr_write(REG_CAPTURE_LENGTH, len | ($urandom() & 32'hFFFF_F800));

         n = $urandom_range(30, 80);
         for (int unsigned k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 55)
               op = OP_CAPTURE;
            else if (sel < 95)
               op = OP_READ;
            else if (sel < 97)
               op = OP_CLEAR;
            else
               op = OP_UNDEFINED;
            // half the left samples land near the trigger level
            if ($urandom_range(0, 1) != 0)
               left = sample_type'($urandom());
            else
               left = trig_level + sample_type'($urandom_range(0, 64)) - sample_type'(32);
            right = sample_type'($urandom());
            chan  = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 6) != 0)
               idx = IBITS'($urandom_range(0, ring_len - 1));
            else
               idx = IBITS'($urandom());
            send_request(op, left, right, chan, idx);
            sent++;
            if ($urandom_range(0, 49) == 0) begin
               drive_idle();
               wait_drained();
            end
         end
      end
   endtask

   initial begin
      reset            <= 1'b1;
      start            <= 1'b0;
      req_op           <= OP_CAPTURE;
      req_sample_left  <= '0;
      req_sample_right <= '0;
      req_read_channel <= 1'b0;
      req_read_index   <= '0;
      csr_valid        <= 1'b0;
      csr_index        <= REG_TRIGGER_LEVEL;
      csr_wdata        <= '0;
      reset_predictor();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_sample_extremes();
      test_unknown_op();
      test_length_limits();
      test_mono_and_bypass();
      test_trigger_sweep();
      test_random_traffic();

      drive_idle();
      wait_drained();
      repeat (4) @(posedge clock);
      $display("Sent %0d captures, %0d reads, %0d clears, %0d undefined ops",
               n_capture, n_read, n_clear, n_other);
      $display("with %0d register writes; %0d mismatches in %0d cycles",
               n_csr, err_count, cycle_count);
      if (err_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
